// ===== src/fat_cluster_sector_translator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// FAT sector translator assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FAT_CLUSTER_SECTOR_TRANSLATOR_UNIT_MACROS_SVH
`define FAT_CLUSTER_SECTOR_TRANSLATOR_UNIT_MACROS_SVH

// same-cycle implication
`define FCST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FCST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/fcst_pkg.sv =====
// ----------------------------------------------------------------------------
// fcst_pkg
// Types, widths and codes shared by the FAT sector translator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fcst_pkg;

    localparam int unsigned CFG_DATA_W   = 32;
    localparam int unsigned CFG_INDEX_W  = 3;
    localparam int unsigned BPS_W        = 13;
    localparam int unsigned SPC_W        = 8;
    localparam int unsigned CLUSTER_W    = 32;
    localparam int unsigned SECT_W       = 8;
    localparam int unsigned BUF_W        = 32;
    localparam int unsigned OFFSET_W     = 44;
    localparam int unsigned COUNT_W      = 20;
    localparam int unsigned DSTART_W     = 40;
    localparam int unsigned SECT_SUM_W   = 41;
    localparam int unsigned RAW_COUNT_W  = BPS_W + SPC_W;
    localparam int unsigned DIV_W        = 32;
    localparam int unsigned DIV_CNT_W    = $clog2(DIV_W);

    localparam logic [CLUSTER_W-1:0]   FAT12_MAX_CLUSTERS = 32'd4085;
    localparam logic [CLUSTER_W-1:0]   FAT16_MAX_CLUSTERS = 32'd65525;
    localparam logic [RAW_COUNT_W-1:0] COUNT_MAX          = 21'h0FFFFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BYTES_PER_SECTOR    = 3'd0,
        REG_SECTORS_PER_CLUSTER = 3'd1,
        REG_RESERVED_SECTORS    = 3'd2,
        REG_FAT_COPIES          = 3'd3,
        REG_ROOT_ENTRY_COUNT    = 3'd4,
        REG_TOTAL_SECTORS       = 3'd5,
        REG_FAT_SIZE_SHORT      = 3'd6,
        REG_FAT_SIZE_LONG       = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_CLUSTER = 2'd1,
        ST_BAD_RANGE  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FT_FAT12 = 2'd0,
        FT_FAT16 = 2'd1,
        FT_FAT32 = 2'd2
    } fat_type_t;

    typedef enum logic [2:0] {
        LY_MUL,
        LY_ROOT_DIV,
        LY_SUM,
        LY_SUB,
        LY_CLUS_DIV,
        LY_TYPE,
        LY_DONE
    } layout_state_t;

    typedef struct packed {
        logic [BPS_W-1:0] bytes_per_sector;
        logic [SPC_W-1:0] sectors_per_cluster;
        logic [15:0]      reserved_sectors;
        logic [7:0]       fat_copies;
        logic [15:0]      root_entry_count;
        logic [31:0]      total_sectors;
        logic [15:0]      fat_size_short;
        logic [31:0]      fat_size_long;
    } cfg_t;

    typedef struct packed {
        logic                  ready;
        logic [DSTART_W-1:0]   data_start;
        logic [CLUSTER_W-1:0]  clusters;
        fat_type_t             fat_type;
    } layout_t;

    typedef struct packed {
        logic ld_root;
        logic step;
        logic sum;
        logic ld_clus;
        logic fin;
    } layout_ctl_t;

endpackage

`default_nettype wire

// ===== src/fcst_layout.sv =====
// ----------------------------------------------------------------------------
// fcst_layout
// Derives the volume layout from the boot-sector registers with a shared
// radix-2 restoring divider; restarts on every register write.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fat_cluster_sector_translator_unit_macros.svh"

module fcst_layout
    import fcst_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    cfg_write,
    input  wire cfg_t    cfg,
    output layout_t      layout
);

    layout_state_t          state_reg;
    layout_state_t          state_next;
    layout_ctl_t            ctl;

    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DIV_W-1:0]       quo_reg;
    logic [BPS_W-1:0]       rem_reg;
    logic [BPS_W-1:0]       div_reg;
    logic [DSTART_W-1:0]    fat_area_reg;
    logic [DSTART_W-1:0]    data_start_reg;
    logic [CLUSTER_W-1:0]   clusters_reg;
    fat_type_t              fat_type_reg;

    logic [31:0]            fat_size;
    logic [21:0]            root_num;
    logic [BPS_W:0]         rem_sh;
    logic                   rem_ge;
    logic [21:0]            root_secs;
    logic [DSTART_W:0]      start_sum;
    logic [31:0]            data_secs;
    logic [CLUSTER_W-1:0]   clus_q;

    assign fat_size  = (cfg.fat_size_short != 16'd0) ? 32'(cfg.fat_size_short)
                                                     : cfg.fat_size_long;
    assign root_num  = {1'b0, cfg.root_entry_count, 5'b0} + 22'(cfg.bytes_per_sector) - 22'd1;
    assign rem_sh    = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_ge    = rem_sh >= {1'b0, div_reg};
    assign root_secs = (cfg.bytes_per_sector == '0) ? '0 : quo_reg[21:0];
    assign start_sum = 41'(cfg.reserved_sectors) + 41'(fat_area_reg) + 41'(root_secs);
    assign data_secs = (41'(cfg.total_sectors) > 41'(data_start_reg))
                     ? cfg.total_sectors - data_start_reg[31:0] : 32'd0;
    assign clus_q    = (cfg.sectors_per_cluster == '0) ? '0 : quo_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (cfg_write)
        begin
            state_next = LY_MUL;
        end
        else
        begin
            unique case (state_reg)
                LY_MUL:      state_next = LY_ROOT_DIV;
                LY_ROOT_DIV: state_next = (cnt_reg == '1) ? LY_SUM : LY_ROOT_DIV;
                LY_SUM:      state_next = LY_SUB;
                LY_SUB:      state_next = LY_CLUS_DIV;
                LY_CLUS_DIV: state_next = (cnt_reg == '1) ? LY_TYPE : LY_CLUS_DIV;
                LY_TYPE:     state_next = LY_DONE;
                LY_DONE:     state_next = LY_DONE;
                default:     state_next = LY_MUL;
            endcase
        end
    end

    // controls
    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            LY_MUL:      ctl.ld_root = 1'b1;
            LY_ROOT_DIV: ctl.step    = 1'b1;
            LY_SUM:      ctl.sum     = 1'b1;
            LY_SUB:      ctl.ld_clus = 1'b1;
            LY_CLUS_DIV: ctl.step    = 1'b1;
            LY_TYPE:     ctl.fin     = 1'b1;
            LY_DONE:     ctl         = '0;
            default:     ctl         = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LY_MUL;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_root)
        begin
            fat_area_reg <= 40'(fat_size) * 40'(cfg.fat_copies);
            quo_reg      <= 32'(root_num);
            rem_reg      <= '0;
            div_reg      <= cfg.bytes_per_sector;
        end
        else if (ctl.ld_clus)
        begin
            quo_reg <= data_secs;
            rem_reg <= '0;
            div_reg <= BPS_W'(cfg.sectors_per_cluster);
        end
        else if (ctl.step)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], rem_ge};
            rem_reg <= rem_ge ? BPS_W'(rem_sh - {1'b0, div_reg}) : rem_sh[BPS_W-1:0];
        end
        if (ctl.sum)
        begin
            data_start_reg <= start_sum[DSTART_W-1:0];
        end
        if (ctl.fin)
        begin
            clusters_reg <= clus_q;
            if (clus_q <= FAT12_MAX_CLUSTERS)
            begin
                fat_type_reg <= FT_FAT12;
            end
            else if (clus_q <= FAT16_MAX_CLUSTERS)
            begin
                fat_type_reg <= FT_FAT16;
            end
            else
            begin
                fat_type_reg <= FT_FAT32;
            end
        end
    end

    assign layout.ready      = (state_reg == LY_DONE);
    assign layout.data_start = data_start_reg;
    assign layout.clusters   = clusters_reg;
    assign layout.fat_type   = fat_type_reg;

    `FCST_ASSERT_NEXT(a_cfg_restart, cfg_write, !layout.ready, "layout not rebuilt after write")
    `FCST_ASSERT_NOW(a_fat12_class, layout.ready && (layout.clusters <= FAT12_MAX_CLUSTERS), layout.fat_type == FT_FAT12, "small volume not FAT12")
    `FCST_ASSERT_NOW(a_spc_zero, layout.ready && (cfg.sectors_per_cluster == '0), layout.clusters == '0, "clusters with empty cluster size")

endmodule

`default_nettype wire

// ===== src/fcst_req_pipe.sv =====
// ----------------------------------------------------------------------------
// fcst_req_pipe
// Three-stage request pipeline: bounds check and cluster scaling, sector sum
// and byte count, byte offset and buffer clip into the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fat_cluster_sector_translator_unit_macros.svh"

module fcst_req_pipe
    import fcst_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [BPS_W-1:0]      bytes_per_sector,
    input  wire logic [SPC_W-1:0]      sectors_per_cluster,
    input  wire layout_t               layout,
    input  wire logic                  in_valid,
    output      logic                  in_stall,
    input  wire logic [CLUSTER_W-1:0]  cluster_index,
    input  wire logic [SECT_W-1:0]     first_sector,
    input  wire logic [SECT_W-1:0]     sector_count,
    input  wire logic [BUF_W-1:0]      buffer_bytes,
    output      logic                  out_valid,
    input  wire logic                  out_stall,
    output      logic [1:0]            status,
    output      logic [OFFSET_W-1:0]   byte_offset,
    output      logic [COUNT_W-1:0]    byte_count,
    output      logic [SECT_W-1:0]     sectors_used,
    output      logic [1:0]            fat_type,
    output      logic [CLUSTER_W-1:0]  cluster_total,
    output      logic [DSTART_W-1:0]   data_start_sector
);

    logic                    advance;
    logic                    accept;

    logic                    s1_valid_reg;
    status_t                 s1_status_reg;
    logic [SECT_W-1:0]       s1_used_reg;
    logic [DSTART_W-1:0]     s1_cl_spc_reg;
    logic [SECT_W-1:0]       s1_first_reg;
    logic [BUF_W-1:0]        s1_buf_reg;

    logic                    s2_valid_reg;
    status_t                 s2_status_reg;
    logic [SECT_W-1:0]       s2_used_reg;
    logic [SECT_SUM_W-1:0]   s2_sect_reg;
    logic [RAW_COUNT_W-1:0]  s2_raw_reg;
    logic [BUF_W-1:0]        s2_buf_reg;

    logic                    s3_valid_reg;
    status_t                 s3_status_reg;
    logic [OFFSET_W-1:0]     s3_offset_reg;
    logic [COUNT_W-1:0]      s3_count_reg;
    logic [SECT_W-1:0]       s3_used_reg;
    fat_type_t               s3_type_reg;
    logic [CLUSTER_W-1:0]    s3_clusters_reg;
    logic [DSTART_W-1:0]     s3_dstart_reg;

    status_t                 s1_status_next;
    logic [SECT_W-1:0]       s1_used_next;
    logic [SECT_W-1:0]       room;
    logic [53:0]             offset_prod;
    logic [COUNT_W-1:0]      count_sat;
    logic [COUNT_W-1:0]      count_clip;
    logic                    s2_ok;

    assign advance  = !(s3_valid_reg && out_stall);
    assign in_stall = !advance || !layout.ready;
    assign accept   = in_valid && !in_stall;

    // stage 1: bounds
    assign room = sectors_per_cluster - first_sector;

    always_comb
    begin
        s1_status_next = ST_OK;
        s1_used_next   = '0;
        priority if (cluster_index >= layout.clusters)
        begin
            s1_status_next = ST_NO_CLUSTER;
        end
        else if (first_sector >= sectors_per_cluster)
        begin
            s1_status_next = ST_BAD_RANGE;
        end
        else if (sector_count == '0)
        begin
            s1_used_next = room;
        end
        else if (sector_count > room)
        begin
            s1_status_next = ST_BAD_RANGE;
        end
        else
        begin
            s1_used_next = sector_count;
        end
    end

    // stage 3: offset and clip
    assign s2_ok       = (s2_status_reg == ST_OK);
    assign offset_prod = 54'(s2_sect_reg) * 54'(bytes_per_sector);
    assign count_sat   = (s2_raw_reg > COUNT_MAX) ? COUNT_MAX[COUNT_W-1:0]
                                                  : s2_raw_reg[COUNT_W-1:0];
    assign count_clip  = (BUF_W'(count_sat) > s2_buf_reg) ? s2_buf_reg[COUNT_W-1:0]
                                                          : count_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_status_reg   <= s1_status_next;
            s1_used_reg     <= s1_used_next;
            s1_cl_spc_reg   <= 40'(cluster_index) * 40'(sectors_per_cluster);
            s1_first_reg    <= first_sector;
            s1_buf_reg      <= buffer_bytes;

            s2_status_reg   <= s1_status_reg;
            s2_used_reg     <= s1_used_reg;
            s2_sect_reg     <= 41'(layout.data_start) + 41'(s1_cl_spc_reg)
                             + 41'(s1_first_reg);
            s2_raw_reg      <= 21'(s1_used_reg) * 21'(bytes_per_sector);
            s2_buf_reg      <= s1_buf_reg;

            s3_status_reg   <= s2_status_reg;
            s3_offset_reg   <= s2_ok ? offset_prod[OFFSET_W-1:0] : '0;
            s3_count_reg    <= s2_ok ? count_clip : '0;
            s3_used_reg     <= s2_used_reg;
            s3_type_reg     <= layout.fat_type;
            s3_clusters_reg <= layout.clusters;
            s3_dstart_reg   <= layout.data_start;
        end
    end

    assign out_valid         = s3_valid_reg;
    assign status            = s3_status_reg;
    assign byte_offset       = s3_offset_reg;
    assign byte_count        = s3_count_reg;
    assign sectors_used      = s3_used_reg;
    assign fat_type          = s3_type_reg;
    assign cluster_total     = s3_clusters_reg;
    assign data_start_sector = s3_dstart_reg;

    `FCST_ASSERT_NOW(a_reject_zero, s3_valid_reg && (s3_status_reg != ST_OK), (s3_offset_reg == '0) && (s3_count_reg == '0) && (s3_used_reg == '0), "rejected request carries data")
    `FCST_ASSERT_NOW(a_ok_used, s3_valid_reg && (s3_status_reg == ST_OK), s3_used_reg != '0, "accepted request with no sectors")
    `FCST_ASSERT_NEXT(a_s2_hold, s2_valid_reg && !advance, s2_valid_reg, "stage 2 lost under stall")

endmodule

`default_nettype wire

// ===== src/fat_cluster_sector_translator_unit.sv =====
// Transfers pass every pipeline register; one per cycle unless out_stall or a rebuild stalls.
// After reset and after every register write the layout is rebuilt by a shared
// 32-step restoring divider (root sectors, then cluster count), with in_stall high meanwhile.
// Reset: registers return to their boot defaults, pipeline valid bits clear.
// ----------------------------------------------------------------------------
// fat_cluster_sector_translator_unit
// Maps a data cluster and sector range to an absolute byte offset and count
// on a FAT12/16/32 volume described by the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_cluster_sector_translator_unit
    import fcst_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_write,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                    in_valid,
    output      logic                    in_stall,
    input  wire logic [CLUSTER_W-1:0]    cluster_index,
    input  wire logic [SECT_W-1:0]       first_sector,
    input  wire logic [SECT_W-1:0]       sector_count,
    input  wire logic [BUF_W-1:0]        buffer_bytes,
    output      logic                    out_valid,
    input  wire logic                    out_stall,
    output      logic [1:0]              status,
    output      logic [OFFSET_W-1:0]     byte_offset,
    output      logic [COUNT_W-1:0]      byte_count,
    output      logic [SECT_W-1:0]       sectors_used,
    output      logic [1:0]              fat_type,
    output      logic [CLUSTER_W-1:0]    cluster_total,
    output      logic [DSTART_W-1:0]     data_start_sector
);

    cfg_t     cfg_reg;
    layout_t  layout;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bytes_per_sector    <= 13'd512;
            cfg_reg.sectors_per_cluster <= 8'd1;
            cfg_reg.reserved_sectors    <= 16'd1;
            cfg_reg.fat_copies          <= 8'd2;
            cfg_reg.root_entry_count    <= 16'd512;
            cfg_reg.total_sectors       <= 32'd0;
            cfg_reg.fat_size_short      <= 16'd0;
            cfg_reg.fat_size_long       <= 32'd0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_BYTES_PER_SECTOR:    cfg_reg.bytes_per_sector    <= cfg_data[BPS_W-1:0];
                REG_SECTORS_PER_CLUSTER: cfg_reg.sectors_per_cluster <= cfg_data[SPC_W-1:0];
                REG_RESERVED_SECTORS:    cfg_reg.reserved_sectors    <= cfg_data[15:0];
                REG_FAT_COPIES:          cfg_reg.fat_copies          <= cfg_data[7:0];
                REG_ROOT_ENTRY_COUNT:    cfg_reg.root_entry_count    <= cfg_data[15:0];
                REG_TOTAL_SECTORS:       cfg_reg.total_sectors       <= cfg_data;
                REG_FAT_SIZE_SHORT:      cfg_reg.fat_size_short      <= cfg_data[15:0];
                REG_FAT_SIZE_LONG:       cfg_reg.fat_size_long       <= cfg_data;
                default:                 cfg_reg                     <= cfg_reg;
            endcase
        end
    end

    fcst_layout u_layout
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg       (cfg_reg),
        .layout    (layout)
    );

    fcst_req_pipe u_req_pipe
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .bytes_per_sector    (cfg_reg.bytes_per_sector),
        .sectors_per_cluster (cfg_reg.sectors_per_cluster),
        .layout              (layout),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .cluster_index       (cluster_index),
        .first_sector        (first_sector),
        .sector_count        (sector_count),
        .buffer_bytes        (buffer_bytes),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .status              (status),
        .byte_offset         (byte_offset),
        .byte_count          (byte_count),
        .sectors_used        (sectors_used),
        .fat_type            (fat_type),
        .cluster_total       (cluster_total),
        .data_start_sector   (data_start_sector)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FAT cluster-to-sector translator. Volume layouts
// are set up through the register port, read requests are streamed in with
// random input gaps and output stalls, and each result transfer is checked
// field by field against a layout and address calculation kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
    import fcst_pkg::*;

    localparam int          CLK_HALF      = 10;
    localparam int          RESET_CYCLES  = 11;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          DRAIN_LIMIT   = 20000;
    localparam int          SETTLE_CYCLES = 8;
    localparam longint      RUN_LIMIT     = 64'd40_000_000;
    localparam logic [63:0] DIR_ENTRY_BYTES = 64'd32;

    typedef struct packed {
        logic [DSTART_W-1:0]  data_start;
        logic [CLUSTER_W-1:0] clusters;
        fat_type_t            ftype;
    } volume_t;

    typedef struct packed {
        status_t              status;
        logic [OFFSET_W-1:0]  offset;
        logic [COUNT_W-1:0]   nbytes;
        logic [SECT_W-1:0]    used;
        volume_t              vol;
    } read_answer_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [CLUSTER_W-1:0]   cluster_index;
    logic [SECT_W-1:0]      first_sector;
    logic [SECT_W-1:0]      sector_count;
    logic [BUF_W-1:0]       buffer_bytes;
    logic                   out_valid;
    logic                   out_stall;
    logic [1:0]             status;
    logic [OFFSET_W-1:0]    byte_offset;
    logic [COUNT_W-1:0]     byte_count;
    logic [SECT_W-1:0]      sectors_used;
    logic [1:0]             fat_type;
    logic [CLUSTER_W-1:0]   cluster_total;
    logic [DSTART_W-1:0]    data_start_sector;

    cfg_t         vol_regs;
    read_answer_t pending_answers[$];
    int           mismatch_count;
    int           requests_sent;
    int           answers_checked;
    int           volumes_programmed;
    int           input_held_cycles;
    int           status_seen[4];
    int           type_seen[4];
    bit           tx_gaps_on;
    int           tx_calm;
    bit           hold_request;

    fat_cluster_sector_translator_unit dut (.*);

    always #(CLK_HALF) clk = ~clk;

    // ---- layout and address calculation ----

    function automatic cfg_t make_volume(input logic [31:0] bps, input logic [31:0] spc,
                                         input logic [31:0] rsv, input logic [31:0] copies,
                                         input logic [31:0] root, input logic [31:0] total,
                                         input logic [31:0] fsz16, input logic [31:0] fsz32);
        cfg_t r;
        r.bytes_per_sector    = bps[BPS_W-1:0];
        r.sectors_per_cluster = spc[SPC_W-1:0];
        r.reserved_sectors    = rsv[15:0];
        r.fat_copies          = copies[7:0];
        r.root_entry_count    = root[15:0];
        r.total_sectors       = total;
        r.fat_size_short      = fsz16[15:0];
        r.fat_size_long       = fsz32;
        return r;
    endfunction

    function automatic volume_t derive_volume(input cfg_t r);
        logic [63:0] bps;
        logic [63:0] spc;
        logic [63:0] fat_sz;
        logic [63:0] root_secs;
        logic [63:0] dstart;
        logic [63:0] data_secs;
        logic [63:0] quot;
        volume_t     v;
        bps    = 64'(r.bytes_per_sector);
        spc    = 64'(r.sectors_per_cluster);
        fat_sz = (r.fat_size_short != '0) ? 64'(r.fat_size_short) : 64'(r.fat_size_long);
        root_secs = (bps != 0) ?
                    (DIR_ENTRY_BYTES * 64'(r.root_entry_count) + bps - 64'd1) / bps : 64'd0;
        dstart = 64'(r.reserved_sectors) + fat_sz * 64'(r.fat_copies) + root_secs;
        v.data_start = dstart[DSTART_W-1:0];
        dstart = 64'(v.data_start);
        data_secs = (64'(r.total_sectors) > dstart) ? 64'(r.total_sectors) - dstart : 64'd0;
        quot = (spc != 0) ? data_secs / spc : 64'd0;
        v.clusters = quot[CLUSTER_W-1:0];
        if (v.clusters <= FAT12_MAX_CLUSTERS)
            v.ftype = FT_FAT12;
        else if (v.clusters <= FAT16_MAX_CLUSTERS)
            v.ftype = FT_FAT16;
        else
            v.ftype = FT_FAT32;
        return v;
    endfunction

    function automatic read_answer_t translate_request(input logic [31:0] cluster,
                                                       input logic [7:0] first,
                                                       input logic [7:0] count,
                                                       input logic [31:0] buffer);
        read_answer_t a;
        logic [63:0]  bps;
        logic [63:0]  spc;
        logic [63:0]  room;
        logic [63:0]  nsec;
        logic [63:0]  nbytes;
        logic [63:0]  sector;
        a.vol    = derive_volume(vol_regs);
        a.status = ST_OK;
        a.offset = '0;
        a.nbytes = '0;
        a.used   = '0;
        bps  = 64'(vol_regs.bytes_per_sector);
        spc  = 64'(vol_regs.sectors_per_cluster);
        room = spc - 64'(first);
        if (cluster >= a.vol.clusters)
            a.status = ST_NO_CLUSTER;
        else if (64'(first) >= spc)
            a.status = ST_BAD_RANGE;
        else if (count != '0 && 64'(count) > room)
            a.status = ST_BAD_RANGE;
        else
        begin
            nsec   = (count == '0) ? room : 64'(count);
            nbytes = nsec * bps;
            if (nbytes > 64'(COUNT_MAX))
                nbytes = 64'(COUNT_MAX);
            if (nbytes > 64'(buffer))
                nbytes = 64'(buffer);
            sector = (64'(a.vol.data_start) + 64'(cluster) * spc + 64'(first)) * bps;
            a.used   = nsec[SECT_W-1:0];
            a.nbytes = nbytes[COUNT_W-1:0];
            a.offset = sector[OFFSET_W-1:0];
        end
        return a;
    endfunction

    // ---- register port ----

    task automatic wait_drained();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (pending_answers.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_BYTES_PER_SECTOR:    vol_regs.bytes_per_sector    = data[BPS_W-1:0];
            REG_SECTORS_PER_CLUSTER: vol_regs.sectors_per_cluster = data[SPC_W-1:0];
            REG_RESERVED_SECTORS:    vol_regs.reserved_sectors    = data[15:0];
            REG_FAT_COPIES:          vol_regs.fat_copies          = data[7:0];
            REG_ROOT_ENTRY_COUNT:    vol_regs.root_entry_count    = data[15:0];
            REG_TOTAL_SECTORS:       vol_regs.total_sectors       = data;
            REG_FAT_SIZE_SHORT:      vol_regs.fat_size_short      = data[15:0];
            REG_FAT_SIZE_LONG:       vol_regs.fat_size_long       = data;
            default: ;
        endcase
    endtask

    // unused upper bits of the write data carry noise when dirty is set
    function automatic logic [31:0] with_junk(input logic [31:0] val, input int w,
                                              input bit dirty);
        return dirty ? (val | (32'($urandom()) << w)) : val;
    endfunction

    task automatic program_volume(input cfg_t v, input bit dirty);
        volume_t lay;
        write_register(REG_BYTES_PER_SECTOR,    with_junk(32'(v.bytes_per_sector), BPS_W, dirty));
        write_register(REG_SECTORS_PER_CLUSTER,
                       with_junk(32'(v.sectors_per_cluster), SPC_W, dirty));
        write_register(REG_RESERVED_SECTORS,    with_junk(32'(v.reserved_sectors), 16, dirty));
        write_register(REG_FAT_COPIES,          with_junk(32'(v.fat_copies), 8, dirty));
        write_register(REG_ROOT_ENTRY_COUNT,    with_junk(32'(v.root_entry_count), 16, dirty));
        write_register(REG_TOTAL_SECTORS,       v.total_sectors);
        write_register(REG_FAT_SIZE_SHORT,      with_junk(32'(v.fat_size_short), 16, dirty));
        write_register(REG_FAT_SIZE_LONG,       v.fat_size_long);
        lay = derive_volume(vol_regs);
        type_seen[lay.ftype]++;
        volumes_programmed++;
    endtask

    // ---- request side ----

    task automatic send_request(input logic [31:0] cluster, input logic [7:0] first,
                                input logic [7:0] count, input logic [31:0] buffer);
        int gap;
        int pick;
        gap  = 0;
        pick = $urandom_range(0, 99);
        if (!tx_gaps_on)
            gap = 0;
        else if (tx_calm > 0)
            tx_calm--;
        else if (pick < 6)
            tx_calm = $urandom_range(10, 60);
        else if (pick < 30)
            gap = $urandom_range(1, 3);
        else if (pick < 35)
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        cluster_index <= cluster;
        first_sector  <= first;
        sector_count  <= count;
        buffer_bytes  <= buffer;
        do @(posedge clk); while (in_stall !== 1'b0);
        pending_answers.push_back(translate_request(cluster, first, count, buffer));
        requests_sent++;
    endtask

    function automatic cfg_t random_volume();
        cfg_t        r;
        volume_t     v;
        logic [63:0] span;
        logic [63:0] spc;
        int unsigned pick;
        int unsigned target;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            r.bytes_per_sector = 13'(512 << $urandom_range(0, 3));
        else if (pick < 80)
            r.bytes_per_sector = 13'($urandom_range(1, 4096));
        else if (pick < 95)
            r.bytes_per_sector = 13'(1 << $urandom_range(0, 12));
        else
            r.bytes_per_sector = 13'($urandom());
        r.sectors_per_cluster = ($urandom_range(0, 9) == 0) ? 8'($urandom())
                                                            : 8'(1 << $urandom_range(0, 7));
        r.reserved_sectors = ($urandom_range(0, 4) == 0) ? 16'($urandom())
                                                         : 16'($urandom_range(0, 64));
        r.fat_copies = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(1, 2));
        case ($urandom_range(0, 2))
            0: r.root_entry_count = '0;
            1: r.root_entry_count = 16'd512;
            default: r.root_entry_count = 16'($urandom());
        endcase
        if ($urandom_range(0, 1) == 1)
        begin
            r.fat_size_short = 16'($urandom_range(1, 400));
            r.fat_size_long  = $urandom();
        end
        else
        begin
            r.fat_size_short = '0;
            r.fat_size_long  = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(1, 20000);
        end
        r.total_sectors = '0;
        v = derive_volume(r);
        case ($urandom_range(0, 3))
            0: target = $urandom_range(0, 5000);
            1: target = $urandom_range(4000, 70000);
            2: target = $urandom();
            default: target = $urandom_range(0, 20);
        endcase
        spc  = (r.sectors_per_cluster != '0) ? 64'(r.sectors_per_cluster) : 64'd1;
        span = 64'(v.data_start) + 64'(target) * spc + 64'($urandom_range(0, 255)) % spc;
        if ($urandom_range(0, 19) == 0)
            r.total_sectors = $urandom();
        else
            r.total_sectors = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
        return r;
    endfunction

    task automatic issue_random_requests(input int total);
        volume_t     v;
        int unsigned spc;
        int unsigned bps;
        int unsigned first;
        int unsigned count;
        int unsigned room;
        int unsigned kind;
        logic [31:0] cluster;
        logic [31:0] buffer;
        v   = derive_volume(vol_regs);
        spc = vol_regs.sectors_per_cluster;
        bps = vol_regs.bytes_per_sector;
        repeat (total)
        begin
            kind    = $urandom_range(0, 99);
            cluster = $urandom();
            first   = $urandom_range(0, 255);
            count   = $urandom_range(0, 255);
            buffer  = $urandom();
            if (kind < 75 && v.clusters != '0 && spc != 0)
            begin
                case ($urandom_range(0, 3))
                    0: cluster = v.clusters - 1;
                    1: cluster = '0;
                    default: cluster = $urandom_range(0, v.clusters - 1);
                endcase
                first = $urandom_range(0, spc - 1);
                room  = spc - first;
                case ($urandom_range(0, 3))
                    0: count = 0;
                    1: count = room;
                    default: count = $urandom_range(1, room);
                endcase
                case ($urandom_range(0, 3))
                    0: buffer = $urandom_range(0, ((count == 0) ? room : count) * bps);
                    1: buffer = 32'hFFFF_FFFF;
                    default: ;
                endcase
            end
            else if (kind < 90 && v.clusters != '0 && spc != 0)
            begin
                // just past the volume end, or past the end of the cluster
                case ($urandom_range(0, 2))
                    0: cluster = v.clusters + $urandom_range(0, 3);
                    1:
                    begin
                        cluster = $urandom_range(0, v.clusters - 1);
                        first   = $urandom_range(spc, 255);
                    end
                    default:
                    begin
                        cluster = $urandom_range(0, v.clusters - 1);
                        first   = $urandom_range(0, spc - 1);
                        room    = spc - first;
                        count   = (room < 255) ? $urandom_range(room + 1, 255) : 255;
                    end
                endcase
            end
            send_request(cluster, 8'(first), 8'(count), buffer);
        end
    endtask

    // ---- result side ----

    initial
    begin : rx_pacing
        int stall_left;
        int calm_left;
        int pick;
        stall_left = 0;
        calm_left  = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            pick = $urandom_range(0, 99);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
                calm_left    = 0;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (calm_left > 0)
                    calm_left--;
                else if (pick < 5)
                    calm_left = $urandom_range(20, 80);
                else if (pick < 25)
                    stall_left = $urandom_range(1, 3);
                else if (pick < 29)
                    stall_left = $urandom_range(10, 40);
            end
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        read_answer_t want;
        if (rst_n === 1'b1)
        begin
            if (in_valid === 1'b1 && in_stall === 1'b1)
                input_held_cycles++;
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (pending_answers.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected", $time);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    check_field("status", 64'(want.status), 64'(status));
                    check_field("byte_offset", 64'(want.offset), 64'(byte_offset));
                    check_field("byte_count", 64'(want.nbytes), 64'(byte_count));
                    check_field("sectors_used", 64'(want.used), 64'(sectors_used));
                    check_field("fat_type", 64'(want.vol.ftype), 64'(fat_type));
                    check_field("cluster_total", 64'(want.vol.clusters), 64'(cluster_total));
                    check_field("data_start_sector", 64'(want.vol.data_start),
                                64'(data_start_sector));
                    status_seen[want.status]++;
                    answers_checked++;
                end
            end
        end
    end

    // ---- tests ----

    task automatic test_boot_defaults();
        // boot values give a zero sector total, so nothing maps
        send_request('0, '0, '0, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 8'hFF, 8'hFF, '0);
        send_request(32'h5A5A_A5A5, 8'h0F, 8'h00, 32'h1234_5678);
    endtask

    task automatic test_fat_type_limits();
        logic [31:0] limits[4];
        limits = '{32'd4085, 32'd4086, 32'd65525, 32'd65526};
        foreach (limits[i])
        begin
            program_volume(make_volume(512, 1, 0, 0, 0, limits[i], 0, 0), 1'b0);
            send_request(limits[i] - 1, '0, 8'd1, 32'd512);
            send_request(limits[i], '0, '0, 32'd512);
        end
    endtask

    task automatic test_request_edges();
        volume_t v;
        program_volume(make_volume(4096, 128, 65535, 255, 65535, 32'hFFFF_FFFF, 65535, 0), 1'b0);
        v = derive_volume(vol_regs);
        send_request('0, '0, '0, 32'hFFFF_FFFF);
        send_request(v.clusters - 1, 8'd127, 8'd1, '0);
        send_request(32'd5, '0, 8'd128, 32'd100000);
        send_request(32'd7, 8'd128, '0, 32'hFFFF_FFFF);
        send_request(32'd11, 8'd100, 8'd29, 32'hFFFF_FFFF);
        send_request(32'd13, 8'd255, 8'd255, 32'hFFFF_FFFF);
        send_request(v.clusters, '0, 8'd1, 32'hFFFF_FFFF);
        // data start well beyond the sector total
        program_volume(make_volume(512, 4, 1, 2, 512, 1000, 0, 32'hFFFF_FFFF), 1'b0);
        send_request('0, '0, '0, 32'hFFFF_FFFF);
        program_volume(make_volume(1, 1, 0, 0, 0, 32'hFFFF_FFFF, 0, 0), 1'b0);
        send_request(32'hFFFF_FFFE, '0, 8'd1, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, '0, 8'd1, 32'hFFFF_FFFF);
        // zero sector size: no root area and no bytes
        program_volume(make_volume(0, 4, 2, 2, 512, 100000, 100, 0), 1'b0);
        send_request(32'd3, 8'd1, '0, 32'hFFFF_FFFF);
        // zero cluster size: every cluster out of range
        program_volume(make_volume(512, 0, 2, 2, 512, 100000, 100, 0), 1'b0);
        send_request('0, '0, '0, 32'hFFFF_FFFF);
        // oversized sector and cluster: count saturates, offset wraps
        program_volume(make_volume(8191, 255, 0, 0, 0, 32'hFFFF_FFFF, 0, 0), 1'b0);
        v = derive_volume(vol_regs);
        send_request(v.clusters - 1, '0, '0, 32'hFFFF_FFFF);
        send_request(32'd1000, 8'd254, 8'd1, 32'd5000);
    endtask

    task automatic test_random_volumes();
        repeat (22)
        begin
            program_volume(random_volume(), 1'b1);
            issue_random_requests(55);
        end
    endtask

    task automatic test_output_backpressure();
        program_volume(make_volume(512, 8, 32, 2, 512, 2000000, 0, 2000), 1'b0);
        tx_gaps_on   = 1'b0;
        hold_request = 1'b1;
        issue_random_requests(120);
        tx_gaps_on   = 1'b1;
    endtask

    initial
    begin : run_sequence
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = REG_BYTES_PER_SECTOR;
        cfg_data      = '0;
        in_valid      = 1'b0;
        cluster_index = '0;
        first_sector  = '0;
        sector_count  = '0;
        buffer_bytes  = '0;
        tx_gaps_on    = 1'b1;
        tx_calm       = 0;
        hold_request  = 1'b0;
        vol_regs      = make_volume(512, 1, 1, 2, 512, 0, 0, 0);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_boot_defaults();
        test_fat_type_limits();
        test_request_edges();
        test_random_volumes();
        test_output_backpressure();

        wait_drained();
        if (pending_answers.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, pending_answers.size());
            mismatch_count += pending_answers.size();
        end
        $display("Covered %0d requests over %0d volume layouts (FAT12/16/32: %0d/%0d/%0d).",
                 requests_sent, volumes_programmed, type_seen[FT_FAT12], type_seen[FT_FAT16],
                 type_seen[FT_FAT32]);
        $display("Checked %0d results: ok %0d, beyond volume %0d, bad range %0d; input held %0d cycles.",
                 answers_checked, status_seen[ST_OK], status_seen[ST_NO_CLUSTER],
                 status_seen[ST_BAD_RANGE], input_held_cycles);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin : run_limit
        #(RUN_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/fcst_pkg.sv
src/fcst_layout.sv
src/fcst_req_pipe.sv
src/fat_cluster_sector_translator_unit.sv
tb/tb_top.sv
